// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the frame builder serializer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define SFB_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SFB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define SFB_ASSERT(lbl, clk, rstn, prop, msg)
`define SFB_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ----- design/sfb_pkg.sv -----
// ---------------------------------------------------------------------------
// Frame builder package
// Shared constants, the queue entry type and the byte-wise CRC-32 update.
// ---------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

  localparam logic [7:0]  SyncFirst     = 8'h53;
  localparam logic [7:0]  SyncSecond    = 8'h79;
  localparam int unsigned FrameOverhead = 10;
  localparam logic [31:0] CrcPoly       = 32'hEDB88320;
  localparam logic [31:0] CrcInit       = 32'hFFFFFFFF;

  // One classified transaction handed from the front end to the serializer.
  typedef struct packed {
    logic        start;       // emit the eight header bytes
    logic        data_valid;  // emit one payload byte
    logic        close;       // emit the two CRC bytes and close the frame
    logic [15:0] total;
    logic [15:0] cmd;
    logic [15:0] seq;
    logic [7:0]  data;
  } sfb_cmd_t;

  // Reflected CRC-32 update by one byte, least significant bit first.
  function automatic logic [31:0] sfb_crc_feed(input logic [31:0] crc,
                                               input logic [7:0]  data);
    logic [31:0] c;
    c = crc ^ {24'h000000, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/sfb_front.sv -----
// ---------------------------------------------------------------------------
// Frame builder front end
// Accepts input transactions, tracks the open frame and classifies each one.
// ---------------------------------------------------------------------------
`default_nettype none

module sfb_front
  import sfb_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        frame_start_i,
  input  wire logic [15:0] cmd_type_i,
  input  wire logic [15:0] seq_id_i,
  input  wire logic [12:0] payload_length_i,
  input  wire logic        has_byte_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        q_full_i,
  output logic             push_o,
  output sfb_cmd_t         entry_o
);

  localparam logic [16:0] LenLimit = 17'(MAX_FRAME_BYTES - FrameOverhead);

  logic        open_q, open_d;
  logic [12:0] rem_q, rem_d;
  logic        accept;
  logic [12:0] len_sat;
  logic        open_mid;
  logic [12:0] rem_mid;
  logic        take;
  logic [12:0] rem_after;
  logic        close_hdr;
  logic        close_byte;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    if ({4'b0000, payload_length_i} > LenLimit) begin
      len_sat = LenLimit[12:0];
    end else begin
      len_sat = payload_length_i;
    end
    open_mid   = frame_start_i ? (len_sat != 13'd0) : open_q;
    rem_mid    = frame_start_i ? len_sat : rem_q;
    take       = has_byte_i && open_mid;
    rem_after  = take ? 13'(rem_mid - 13'd1) : rem_mid;
    close_hdr  = frame_start_i && (len_sat == 13'd0);
    close_byte = take && (rem_after == 13'd0);
    open_d     = open_mid && !close_byte;
    rem_d      = rem_after;
  end

  always_comb begin
    entry_o.start      = frame_start_i;
    entry_o.data_valid = take;
    entry_o.close      = close_hdr || close_byte;
    entry_o.total      = 16'({3'b000, len_sat} + 16'(FrameOverhead));
    entry_o.cmd        = cmd_type_i;
    entry_o.seq        = seq_id_i;
    entry_o.data       = data_byte_i;
  end

  // Transactions that produce no byte are consumed here and never queued.
  assign push_o = accept && (frame_start_i || take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rem_q  <= 13'd0;
    end else if (accept) begin
      open_q <= open_d;
      rem_q  <= rem_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/sfb_queue.sv -----
// ---------------------------------------------------------------------------
// Frame builder command queue
// Short FIFO between the front end and the byte serializer.
// ---------------------------------------------------------------------------
`default_nettype none

module sfb_queue
  import sfb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire sfb_cmd_t entry_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          head_valid_o,
  output sfb_cmd_t      head_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  sfb_cmd_t          slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o       = (count_q == (PtrW+1)'(Depth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = slots_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= (PtrW+1)'(count_q + 1'b1);
      end else if (do_pop && !do_push) begin
        count_q <= (PtrW+1)'(count_q - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/sfb_back.sv -----
// ---------------------------------------------------------------------------
// Frame builder serializer
// Turns queued transactions into frame bytes and keeps the running CRC.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfb_back
  import sfb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        head_valid_i,
  input  wire sfb_cmd_t    head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             frame_end_o,
  output logic             run_last_o
);

  // Byte positions within one transaction; the header uses the low three bits.
  localparam logic [3:0] PhHdr0  = 4'd0;
  localparam logic [3:0] PhHdr7  = 4'd7;
  localparam logic [3:0] PhData  = 4'd8;
  localparam logic [3:0] PhCrcLo = 4'd9;
  localparam logic [3:0] PhCrcHi = 4'd10;

  logic        begun_q, begun_d;
  logic [3:0]  phase_q, phase_d;
  logic [31:0] crc_q, crc_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        frame_end_q;
  logic        run_last_q;

  logic [3:0]  first_phase;
  logic [3:0]  cur_phase;
  logic [3:0]  next_phase;
  logic        last;
  logic        advance;
  logic        emit;
  logic [7:0]  hdr_byte;
  logic [7:0]  byte_sel;
  logic [31:0] crc_base;

  always_comb begin
    if (head_i.start) begin
      first_phase = PhHdr0;
    end else if (head_i.data_valid) begin
      first_phase = PhData;
    end else begin
      first_phase = PhCrcLo;
    end
  end

  assign cur_phase = begun_q ? phase_q : first_phase;
  assign advance   = !out_valid_q || out_ready_i;
  assign emit      = head_valid_i && advance;

  always_comb begin
    case (cur_phase[2:0])
      3'd0:    hdr_byte = SyncFirst;
      3'd1:    hdr_byte = SyncSecond;
      3'd2:    hdr_byte = head_i.total[7:0];
      3'd3:    hdr_byte = head_i.total[15:8];
      3'd4:    hdr_byte = head_i.cmd[7:0];
      3'd5:    hdr_byte = head_i.cmd[15:8];
      3'd6:    hdr_byte = head_i.seq[7:0];
      default: hdr_byte = head_i.seq[15:8];
    endcase
  end

  always_comb begin
    byte_sel   = hdr_byte;
    next_phase = 4'(cur_phase + 4'd1);
    last       = 1'b0;
    case (cur_phase)
      PhHdr7: begin
        next_phase = head_i.data_valid ? PhData : PhCrcLo;
        last       = !head_i.data_valid && !head_i.close;
      end
      PhData: begin
        byte_sel   = head_i.data;
        next_phase = PhCrcLo;
        last       = !head_i.close;
      end
      PhCrcLo: begin
        byte_sel   = ~crc_q[7:0];
        next_phase = PhCrcHi;
      end
      PhCrcHi: begin
        byte_sel   = ~crc_q[15:8];
        next_phase = PhHdr0;
        last       = 1'b1;
      end
      default: begin
        byte_sel   = hdr_byte;
      end
    endcase
  end

  // A header restarts the CRC, which also drops whatever an abandoned frame left.
  assign crc_base = (cur_phase == PhHdr0) ? CrcInit : crc_q;

  always_comb begin
    crc_d       = crc_q;
    begun_d     = begun_q;
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = head_valid_i;
    end
    if (emit) begin
      begun_d = !last;
      phase_d = next_phase;
      if (cur_phase == PhCrcHi) begin
        crc_d = CrcInit;
      end else if (cur_phase != PhCrcLo) begin
        crc_d = sfb_crc_feed(crc_base, byte_sel);
      end
    end
  end

  assign pop_o = emit && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begun_q     <= 1'b0;
      phase_q     <= PhHdr0;
      crc_q       <= CrcInit;
      out_valid_q <= 1'b0;
    end else begin
      begun_q     <= begun_d;
      phase_q     <= phase_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q  <= byte_sel;
      frame_end_q <= (cur_phase == PhCrcHi);
      run_last_q  <= last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign frame_end_o = frame_end_q;
  assign run_last_o  = run_last_q;

  `SFB_ASSERT(a_end_is_last, clk_i, rst_ni, out_valid_q && frame_end_q |-> run_last_q, "frame end without run end")
  `SFB_ASSERT_NEVER(a_begun_no_head, clk_i, rst_ni, begun_q && !head_valid_i, "transaction in progress with empty queue")
  `SFB_ASSERT(a_crc_restart, clk_i, rst_ni, emit && (cur_phase == PhCrcHi) |=> (crc_q == CrcInit), "CRC not restarted after frame close")

endmodule

`default_nettype wire

// ----- design/sync_frame_builder_crc_unit.sv -----
// ---------------------------------------------------------------------------
// Sync frame builder with CRC
// Builds length-prefixed frames with a sync word and a 16-bit trailer cut from a CRC-32.
// ---------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_ready_o  frame_start, cmd_type, seq_id,
//                                              payload_length, has_byte, data_byte
//   out      output     out_valid_o/out_ready_i out_byte, frame_end, run_last
//
// The serializer emits one frame byte per cycle unless out_ready_i or an empty
// queue holds it; a transaction yields 0 to 11 bytes (8 header, 1 payload, 2 CRC).
// Input transactions are taken every cycle while the 4-entry command queue has
// room; those producing no byte never enter the queue.
// Reset is ready at once: no clearing pass. The output register keeps taking
// bytes while an earlier byte is being accepted downstream.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_frame_builder_crc_unit
  import sfb_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 8192
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        frame_start_i,
  input  wire logic [15:0] cmd_type_i,
  input  wire logic [15:0] seq_id_i,
  input  wire logic [12:0] payload_length_i,
  input  wire logic        has_byte_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic             frame_end_o,
  output logic             run_last_o
);

  logic     q_full;
  logic     push;
  sfb_cmd_t entry;
  logic     pop;
  logic     head_valid;
  sfb_cmd_t head;

  sfb_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_start_i    (frame_start_i),
    .cmd_type_i       (cmd_type_i),
    .seq_id_i         (seq_id_i),
    .payload_length_i (payload_length_i),
    .has_byte_i       (has_byte_i),
    .data_byte_i      (data_byte_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .entry_o          (entry)
  );

  sfb_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  sfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o),
    .run_last_o   (run_last_o)
  );

endmodule

`default_nettype wire

// ----- sim/sync_frame_builder_crc_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sync frame builder testbench
// Drives command and payload transactions into the frame builder and checks
// every emitted stream byte against a cycle-free prediction of the frame
// encoding: sync word, length, command, sequence id, payload and CRC trailer.
// ---------------------------------------------------------------------------

module sync_frame_builder_crc_unit_tb;
  import sfb_pkg::*;

  localparam int MaxFrameBytes = 8192;
  localparam int MaxPayload    = MaxFrameBytes - FrameOverhead;
  localparam int CycleLimit    = 400000;
  localparam int HoldCycles    = 250;
  localparam int DrainCycles   = 30;

  typedef struct packed {
    logic        start;
    logic [15:0] cmd;
    logic [15:0] seq;
    logic [12:0] len;
    logic        has;
    logic [7:0]  data;
  } frame_item_t;

  typedef struct {
    logic [7:0] value;
    logic       frame_end;
    logic       run_last;
  } stream_byte_t;

  // Predicts the byte stream of the encoder and checks what comes out.
  class frame_stream_checker;
    stream_byte_t expected_bytes[$];
    logic [31:0]  crc;
    int           remaining;
    bit           open;
    int           errors;

    function new();
      crc       = CrcInit;
      remaining = 0;
      open      = 1'b0;
      errors    = 0;
    endfunction

    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
        r = (r >> 1) ^ (CrcPoly & {32{r[0] ^ b[i]}});
      end
      return r;
    endfunction

    function void push_byte(logic [7:0] v, logic fe);
      stream_byte_t e;
      e.value     = v;
      e.frame_end = fe;
      e.run_last  = 1'b0;
      expected_bytes.push_back(e);
    endfunction

    function void push_data(logic [7:0] v);
      crc = crc_step(crc, v);
      push_byte(v, 1'b0);
    endfunction

    function void close_frame();
      logic [31:0] fcs;
      fcs = ~crc;
      push_byte(fcs[7:0], 1'b0);
      push_byte(fcs[15:8], 1'b1);
      crc       = CrcInit;
      remaining = 0;
      open      = 1'b0;
    endfunction

    // Returns the number of stream bytes this transaction produces.
    function int take_item(frame_item_t it);
      int          first;
      int          plen;
      logic [15:0] total;
      first = expected_bytes.size();
      if (it.start) begin
        plen  = (int'(it.len) > MaxPayload) ? MaxPayload : int'(it.len);
        total = 16'(plen + FrameOverhead);
        crc   = CrcInit;
        push_data(SyncFirst);
        push_data(SyncSecond);
        push_data(total[7:0]);
        push_data(total[15:8]);
        push_data(it.cmd[7:0]);
        push_data(it.cmd[15:8]);
        push_data(it.seq[7:0]);
        push_data(it.seq[15:8]);
        remaining = plen;
        open      = 1'b1;
        if (remaining == 0) close_frame();
      end
      if (it.has && open) begin
        push_data(it.data);
        remaining--;
        if (remaining == 0) close_frame();
      end
      if (expected_bytes.size() > first) expected_bytes[$].run_last = 1'b1;
      return expected_bytes.size() - first;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    task check_byte(logic [7:0] v, logic fe, logic rl);
      stream_byte_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h end=%b last=%b", v, fe, rl));
      end else begin
        e = expected_bytes.pop_front();
        if (v !== e.value)
          report($sformatf("out_byte %02h, predicted %02h", v, e.value));
        if (fe !== e.frame_end)
          report($sformatf("frame_end %b, predicted %b", fe, e.frame_end));
        if (rl !== e.run_last)
          report($sformatf("run_last %b, predicted %b", rl, e.run_last));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        frame_start_i;
  logic [15:0] cmd_type_i;
  logic [15:0] seq_id_i;
  logic [12:0] payload_length_i;
  logic        has_byte_i;
  logic [7:0]  data_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  out_byte_o;
  logic        frame_end_o;
  logic        run_last_o;

  frame_stream_checker sb;
  int idle_pct;
  int stall_pct;
  int items_sent;
  int cycle_count;
  int hold_left;
  bit hold_request;

  sync_frame_builder_crc_unit #(
    .MAX_FRAME_BYTES(MaxFrameBytes)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .frame_start_i   (frame_start_i),
    .cmd_type_i      (cmd_type_i),
    .seq_id_i        (seq_id_i),
    .payload_length_i(payload_length_i),
    .has_byte_i      (has_byte_i),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .frame_end_o     (frame_end_o),
    .run_last_o      (run_last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("sync_frame_builder_crc_unit_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_byte(out_byte_o, frame_end_o, run_last_o);
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HoldCycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  function automatic frame_item_t mk(logic start, logic [15:0] cmd, logic [15:0] seq,
                                     logic [12:0] len, logic has, logic [7:0] data);
    frame_item_t it;
    it.start = start;
    it.cmd   = cmd;
    it.seq   = seq;
    it.len   = len;
    it.has   = has;
    it.data  = data;
    return it;
  endfunction

  function automatic frame_item_t rand_fields();
    return mk(1'b0, 16'($urandom), 16'($urandom), 13'($urandom), 1'b0, 8'($urandom));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input frame_item_t it);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    frame_start_i    <= it.start;
    cmd_type_i       <= it.cmd;
    seq_id_i         <= it.seq;
    payload_length_i <= it.len;
    has_byte_i       <= it.has;
    data_byte_i      <= it.data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    void'(sb.take_item(it));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_payload(int count);
    frame_item_t it;
    for (int i = 0; i < count; i++) begin
      it = rand_fields();
      // An occasional empty transaction inside the frame.
      if ($urandom_range(0, 9) == 0) send_item(it);
      it.has = 1'b1;
      send_item(it);
    end
  endtask

  task automatic random_traffic(int target);
    int          goal;
    int          pick;
    int          plen;
    int          sent;
    frame_item_t it;
    goal = items_sent + target;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Well-formed frame, mostly short.
        pick = $urandom_range(0, 99);
        if (pick < 60) plen = $urandom_range(0, 8);
        else if (pick < 90) plen = $urandom_range(9, 40);
        else plen = $urandom_range(41, 120);
        it       = rand_fields();
        it.start = 1'b1;
        it.len   = 13'(plen);
        it.has   = (plen > 0) && ($urandom_range(0, 1) == 1);
        send_item(it);
        sent = it.has ? 1 : 0;
        send_payload(plen - sent);
      end else if (pick < 80) begin
        // Frame cut short: the next start abandons it.
        it       = rand_fields();
        it.start = 1'b1;
        it.has   = 1'($urandom_range(0, 1));
        if (it.len < 13'd6) it.len = 13'd6;
        send_item(it);
        send_payload($urandom_range(0, 4));
        it       = rand_fields();
        it.start = 1'b1;
        it.len   = 13'($urandom_range(0, 6));
        send_item(it);
        send_payload(int'(it.len));
      end else begin
        // Noise: random bits, no start.
        repeat ($urandom_range(1, 4)) begin
          it     = rand_fields();
          it.has = 1'($urandom_range(0, 1));
          send_item(it);
        end
      end
    end
  endtask

  initial begin
    sb               = new();
    idle_pct         = 0;
    stall_pct        = 0;
    items_sent       = 0;
    cycle_count      = 0;
    hold_left        = 0;
    hold_request     = 1'b0;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    out_ready_i      = 1'b0;
    frame_start_i    = 1'b0;
    cmd_type_i       = '0;
    seq_id_i         = '0;
    payload_length_i = '0;
    has_byte_i       = 1'b0;
    data_byte_i      = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed cases, no idling on either side.
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'hFF)); // byte, no frame
    send_item(mk(1'b1, 16'h0000, 16'h0000, 13'h0000, 1'b0, 8'h00)); // empty payload
    send_item(mk(1'b1, 16'hFFFF, 16'hFFFF, 13'h0000, 1'b1, 8'hFF)); // empty, byte dropped
    send_item(mk(1'b1, 16'h1234, 16'h8001, 13'h0001, 1'b1, 8'h00)); // start carries byte
    send_item(mk(1'b1, 16'hA5A5, 16'h5A5A, 13'h0003, 1'b0, 8'h00));
    send_item(mk(1'b0, 16'hFFFF, 16'hFFFF, 13'h1FFF, 1'b0, 8'hFF)); // no byte
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'hFF));
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'h00));
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'h80)); // closes
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'h55)); // stray byte
    send_item(mk(1'b1, 16'h00FF, 16'hFF00, 13'h0005, 1'b0, 8'h00));
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'h3C));
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'hC3));
    send_item(mk(1'b1, 16'hFFFF, 16'h0000, 13'h1FFF, 1'b0, 8'h00)); // abandon, saturate
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'h01));
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'hFE));
    send_item(mk(1'b1, 16'h0001, 16'h0002, 13'(MaxPayload), 1'b0, 8'h00)); // at limit
    send_item(mk(1'b1, 16'h8000, 16'h7FFF, 13'(MaxPayload + 1), 1'b1, 8'hAA));
    send_item(mk(1'b1, 16'h0000, 16'hFFFF, 13'h0002, 1'b0, 8'h00));
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'h11));
    send_item(mk(1'b0, 16'h0000, 16'h0000, 13'h0000, 1'b1, 8'h22)); // closes

    // Long receiver hold-off while a long frame keeps coming.
    hold_request = 1'b1;
    send_item(mk(1'b1, 16'h0BAD, 16'h0001, 13'd40, 1'b0, 8'h00));
    send_payload(40);
    random_traffic(35);

    idle_pct  = 54;
    stall_pct = 0;
    random_traffic(35);
    idle_pct  = 0;
    stall_pct = 54;
    random_traffic(35);
    idle_pct  = 38;
    stall_pct = 38;
    random_traffic(35);

    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.expected_bytes.size() != 0)
      sb.report($sformatf("%0d predicted bytes never came", sb.expected_bytes.size()));
    if (sb.errors == 0) begin
      $display("sync_frame_builder_crc_unit_tb: done, clean");
    end else begin
      $display("sync_frame_builder_crc_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/sfb_pkg.sv
design/sfb_front.sv
design/sfb_queue.sv
design/sfb_back.sv
design/sync_frame_builder_crc_unit.sv
sim/sync_frame_builder_crc_unit_tb.sv
